[rtl/mrd_pkg.sv]
// Shared constants, codes and beat layouts of the MMIO region decoder.
`default_nettype none

package mrd_pkg;

  localparam int POOL_BYTES = 4096;
  localparam int REGIONS    = 8;

  // Pool is split into byte lanes so one access of up to four bytes hits each lane at most once.
  localparam int LANES  = 4;
  localparam int LANE_W = $clog2(LANES);
  localparam int ROWS   = POOL_BYTES / LANES;
  localparam int ROW_W  = $clog2(ROWS);

  localparam int CNT_W  = $clog2(REGIONS + 1);
  localparam int OFF_W  = $clog2(POOL_BYTES + 1);
  localparam int POS_W  = 34;

  localparam int ADDR_W = 32;
  localparam int DATA_W = 32;
  localparam int LEN_W  = 13;
  localparam int SEL_W  = 3;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 3;

  localparam int IN_W   = 88;
  localparam int OUT_W  = 56;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIND  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd1;
  localparam logic [STAT_W-1:0] ST_POOL_FULL  = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_LEN    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_REGION  = 3'd4;

  // Input beat, first field in the low bits.
  typedef struct packed {
    logic [6:0]        pad;
    logic [DATA_W-1:0] write_data;
    logic [SEL_W-1:0]  region_select;
    logic              has_notify;
    logic [LEN_W-1:0]  length;
    logic [ADDR_W-1:0] addr;
  } in_item_t;

  // Result beat, first field in the low bits.
  typedef struct packed {
    logic [1:0]        pad;
    logic              notify_write;
    logic              notify;
    logic [LEN_W-1:0]  base_offset;
    logic [DATA_W-1:0] read_data;
    logic [SEL_W-1:0]  region_index;
    logic              hit;
    logic [STAT_W-1:0] status;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/mrd_bank_ram.sv]
// Single-port synchronous RAM with registered read data, one pool byte lane.
`default_nettype none

module mrd_bank_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    // hold read data between reads
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[rtl/mmio_region_decoder.sv]
// MMIO region decoder: region table, byte pool and command sequencer.
//
// Input beats arrive on s_axis_*, with the command in s_axis_tuser (add, find,
// read, write) and the operands in s_axis_tdata. Every beat gives exactly one
// result beat on m_axis_*, in order.
// A beat is registered at the accepting edge, the pool RAM is accessed in
// S_MEM, and the result is loaded into the output register from S_DONE when the
// output register is free. One beat is in flight at a time; the next beat is
// taken in the cycle the previous result is loaded. The steps are the pool RAM
// access (address compute and bank access) and the read-data return.
// The region table (8 entries) is in flip-flops: add writes it and find
// compares all entries in parallel at the accepting edge.
// The byte pool is four 1024 x 8 lane RAMs. After reset the lanes are swept
// to zero, one row per cycle, through all 1024 rows; s_axis_tready stays low during
// the sweep. Reset also empties the region table and frees the pool.
// When the receiver stalls, the result is held in the output register, the
// next beat may still be accepted, and it waits after its RAM access until the
// output register drains.
`default_nettype none

module mmio_region_decoder (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // addr, length, has_notify, region_select, write_data, zero pad
  input  wire logic [mrd_pkg::IN_W-1:0]    s_axis_tdata,
  // cmd
  input  wire logic [mrd_pkg::CMD_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // status, hit, region_index, read_data, base_offset, notify, notify_write, zero pad
  output logic      [mrd_pkg::OUT_W-1:0]   m_axis_tdata
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_MEM, S_DONE} state_t;

  state_t state;

  mrd_pkg::in_item_t  item;
  mrd_pkg::out_item_t res_next;
  mrd_pkg::out_item_t res;
  mrd_pkg::out_item_t res_out;
  mrd_pkg::out_item_t out_reg;

  logic accept;
  logic out_free;

  logic [mrd_pkg::ROW_W-1:0]  clr_row;

  // region table
  logic [mrd_pkg::ADDR_W-1:0] reg_start [mrd_pkg::REGIONS];
  logic [mrd_pkg::ADDR_W-1:0] reg_end   [mrd_pkg::REGIONS];
  logic [mrd_pkg::OFF_W-1:0]  reg_base  [mrd_pkg::REGIONS];
  logic [mrd_pkg::REGIONS-1:0] reg_ntf;
  logic [mrd_pkg::CNT_W-1:0]  reg_count;
  logic [mrd_pkg::OFF_W-1:0]  free_off;

  // accept-cycle decode
  logic                       do_add;
  logic                       do_access;
  logic [mrd_pkg::REGIONS-1:0] match;
  logic [mrd_pkg::ADDR_W-1:0] diff_next;

  // operation held for the RAM cycle
  logic                       op_access;
  logic                       op_rd;
  logic                       op_wr;
  logic [2:0]                 op_len;
  logic [mrd_pkg::DATA_W-1:0] op_wdata;
  logic [mrd_pkg::ADDR_W-1:0] op_diff;
  logic [mrd_pkg::OFF_W-1:0]  op_base;

  // lane addressing
  logic [mrd_pkg::POS_W-1:0]  pos;
  logic [mrd_pkg::POS_W-1:0]  q [mrd_pkg::LANES];
  logic [mrd_pkg::LANES-1:0]  lane_ok;
  logic [mrd_pkg::LANE_W-1:0] kb [mrd_pkg::LANES];

  logic                       bank_we    [mrd_pkg::LANES];
  logic                       bank_re    [mrd_pkg::LANES];
  logic [mrd_pkg::ROW_W-1:0]  bank_addr  [mrd_pkg::LANES];
  logic [7:0]                 bank_wdata [mrd_pkg::LANES];
  logic [7:0]                 bank_rdata [mrd_pkg::LANES];

  // read return
  logic [mrd_pkg::LANE_W-1:0] rd_p0;
  logic [mrd_pkg::LANES-1:0]  rd_lane;
  logic [mrd_pkg::LANE_W-1:0] lane_b [mrd_pkg::LANES];
  logic [mrd_pkg::DATA_W-1:0] rdata_asm;

  assign item          = s_axis_tdata;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) || ((state == S_DONE) && out_free);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = out_reg;

  // Decode the command against the region table.
  always_comb begin
    res_next  = '0;
    do_add    = 1'b0;
    do_access = 1'b0;
    diff_next = item.addr - reg_start[item.region_select];
    for (int i = 0; i < mrd_pkg::REGIONS; i++) begin
      match[i] = (mrd_pkg::CNT_W'(i) < reg_count) && (item.addr >= reg_start[i]) &&
                 (item.addr <= reg_end[i]);
    end
    unique case (s_axis_tuser)
      mrd_pkg::CMD_ADD: begin
        if (item.length == '0) begin
          res_next.status = mrd_pkg::ST_BAD_LEN;
        end else if (reg_count == mrd_pkg::CNT_W'(mrd_pkg::REGIONS)) begin
          res_next.status = mrd_pkg::ST_TABLE_FULL;
        end else if (32'(free_off) + 32'(item.length) > 32'(mrd_pkg::POOL_BYTES)) begin
          res_next.status = mrd_pkg::ST_POOL_FULL;
        end else begin
          do_add               = 1'b1;
          res_next.base_offset = mrd_pkg::LEN_W'(free_off);
        end
      end
      mrd_pkg::CMD_FIND: begin
        // lowest matching region wins
        for (int i = mrd_pkg::REGIONS - 1; i >= 0; i--) begin
          if (match[i]) begin
            res_next.hit          = 1'b1;
            res_next.region_index = mrd_pkg::SEL_W'(i);
          end
        end
      end
      mrd_pkg::CMD_READ, mrd_pkg::CMD_WRITE: begin
        if (item.length < 13'd1 || item.length > 13'd4) begin
          res_next.status = mrd_pkg::ST_BAD_LEN;
        end else if (mrd_pkg::CNT_W'(item.region_select) >= reg_count) begin
          res_next.status = mrd_pkg::ST_NO_REGION;
        end else begin
          do_access = 1'b1;
          if (reg_ntf[item.region_select]) begin
            res_next.notify       = 1'b1;
            res_next.notify_write = (s_axis_tuser == mrd_pkg::CMD_WRITE);
          end
        end
      end
      default: res_next = '0;
    endcase
  end

  // Pool position and per-lane RAM control.
  always_comb begin
    pos = mrd_pkg::POS_W'(op_diff) + mrd_pkg::POS_W'(op_base);
    for (int k = 0; k < mrd_pkg::LANES; k++) begin
      q[k]       = pos + mrd_pkg::POS_W'(k);
      lane_ok[k] = op_access && (3'(k) < op_len) &&
                   (q[k] < mrd_pkg::POS_W'(mrd_pkg::POOL_BYTES));
    end
    for (int b = 0; b < mrd_pkg::LANES; b++) begin
      kb[b] = mrd_pkg::LANE_W'(b) - pos[mrd_pkg::LANE_W-1:0];
      if (state == S_CLEAR) begin
        bank_we[b]    = 1'b1;
        bank_re[b]    = 1'b0;
        bank_addr[b]  = clr_row;
        bank_wdata[b] = 8'h00;
      end else if (state == S_MEM) begin
        bank_we[b]    = lane_ok[kb[b]] && op_wr;
        bank_re[b]    = lane_ok[kb[b]] && op_rd;
        bank_addr[b]  = q[kb[b]][mrd_pkg::ROW_W+mrd_pkg::LANE_W-1:mrd_pkg::LANE_W];
        bank_wdata[b] = op_wdata[{kb[b], 3'b000} +: 8];
      end else begin
        bank_we[b]    = 1'b0;
        bank_re[b]    = 1'b0;
        bank_addr[b]  = '0;
        bank_wdata[b] = 8'h00;
      end
    end
  end

  // Gather returned lane bytes into the little-endian word.
  always_comb begin
    for (int k = 0; k < mrd_pkg::LANES; k++) begin
      lane_b[k]          = rd_p0 + mrd_pkg::LANE_W'(k);
      rdata_asm[8*k +: 8] = rd_lane[k] ? bank_rdata[lane_b[k]] : 8'h00;
    end
  end

  // Merge the returned read data into the held result.
  always_comb begin
    res_out           = res;
    res_out.read_data = rdata_asm;
  end

  for (genvar b = 0; b < mrd_pkg::LANES; b++) begin : g_lane
    mrd_bank_ram #(
      .DEPTH (mrd_pkg::ROWS),
      .WIDTH (8)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[b]),
      .re    (bank_re[b]),
      .addr  (bank_addr[b]),
      .wdata (bank_wdata[b]),
      .rdata (bank_rdata[b])
    );
  end

  // Sequencer, table counters and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_row       <= '0;
      reg_count     <= '0;
      free_off      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      if (accept && do_add) begin
        reg_count <= reg_count + 1'b1;
        free_off  <= free_off + mrd_pkg::OFF_W'(item.length);
      end
      unique case (state)
        S_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == mrd_pkg::ROW_W'(mrd_pkg::ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_MEM;
          end
        end
        S_MEM: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            out_reg       <= res_out;
            state         <= accept ? S_MEM : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Region table and operation payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      res       <= res_next;
      op_access <= do_access;
      op_rd     <= do_access && (s_axis_tuser == mrd_pkg::CMD_READ);
      op_wr     <= do_access && (s_axis_tuser == mrd_pkg::CMD_WRITE);
      op_len    <= item.length[2:0];
      op_wdata  <= item.write_data;
      op_diff   <= diff_next;
      op_base   <= reg_base[item.region_select];
      if (do_add) begin
        reg_start[reg_count[mrd_pkg::SEL_W-1:0]] <= item.addr;
        reg_end[reg_count[mrd_pkg::SEL_W-1:0]]   <=
          item.addr + mrd_pkg::ADDR_W'(item.length) - 32'd1;
        reg_base[reg_count[mrd_pkg::SEL_W-1:0]]  <= free_off;
        reg_ntf[reg_count[mrd_pkg::SEL_W-1:0]]   <= item.has_notify;
      end
    end
    if (state == S_MEM) begin
      rd_p0   <= pos[mrd_pkg::LANE_W-1:0];
      rd_lane <= lane_ok & {mrd_pkg::LANES{op_rd}};
    end
  end

endmodule

`default_nettype wire

[rtl/mrd_checker.sv]
// Port-level checks of the MMIO region decoder, bound to the top level.
`default_nettype none

module mrd_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_axis_tvalid,
  input wire logic                      s_axis_tready,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [mrd_pkg::OUT_W-1:0] m_axis_tdata
);

  logic acc;
  mrd_pkg::out_item_t res;

  assign acc = s_axis_tvalid && s_axis_tready;
  assign res = m_axis_tdata;

  // pool sweep follows reset: no beat taken right after it
  a_clear_after_rst: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !s_axis_tready)
    else $error("input ready during pool clear");

  // one beat in flight: never two accepts back to back
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    acc |=> !acc)
    else $error("accepted beats in consecutive cycles");

  // a result beat is presented after every accepted beat
  a_result_due: assert property (@(posedge clk) disable iff (rst)
    acc |-> ##3 m_axis_tvalid)
    else $error("result beat missing");

  a_notify_dir: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.notify || !res.notify_write))
    else $error("notify direction without notify");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result beat changed");

endmodule

bind mmio_region_decoder mrd_checker u_mrd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
